// File: rtl/core/kthf_pkg.sv
// ---------------------------------------------------------------------------
// kthf_pkg
// Types, constants and fixed-point helpers of the tilt/heading Kalman filter.
// ---------------------------------------------------------------------------
package kthf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_IDX_W       = 5;
  localparam int DIV_W            = 48;
  localparam int DIV_CNT_W        = 6;

  localparam logic signed [31:0] HALF_PI_Q  = 32'sd102944;
  localparam logic signed [31:0] K_TILT     = 32'sd3756841;
  localparam logic signed [31:0] K_HEAD     = -32'sd3754951;
  localparam logic signed [47:0] DEG270     = 48'sd17694720;
  localparam logic signed [47:0] DEG360     = 48'sd23592960;
  localparam logic signed [47:0] GYRO_SCALE = 48'sd500;
  localparam logic [31:0]        DT_ROUND   = 32'd500;
  // floor(n / 1000) for n below 2^27 is (n * DT_RECIP) >> DT_SHIFT
  localparam logic [31:0]        DT_RECIP   = 32'd137438954;
  localparam int                 DT_SHIFT   = 37;
  localparam logic signed [16:0] MAG_Z_OFS  = 17'sd127;
  localparam logic signed [16:0] MAG_X_OFS  = 17'sd102;

  typedef enum logic [1:0] {
    REG_PERIOD  = 2'd0,
    REG_ANGLE_N = 2'd1,
    REG_BIAS_N  = 2'd2,
    REG_MEAS_N  = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_MEAS, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5,
    S_K0, S_K1, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6, S_U7, S_DONE
  } state_t;

  typedef struct packed {
    logic              kind;
    logic              tilt_axis;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] acc_first;
    logic signed [15:0] acc_second;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         axis_id;
    logic signed [31:0] filtered_angle;
    logic signed [31:0] measured_angle;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Round to nearest (add half, floor) and drop 16 fraction bits
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd32768) >>> 16;
    return sat32(r[47:0]);
  endfunction

  function automatic logic signed [31:0] gain_fix(input logic [47:0] q, input logic neg);
    logic [31:0] lo;
    lo = q[31:0];
    if (!neg) begin
      if (q > 48'd2147483647) begin
        return 32'sh7FFFFFFF;
      end
      return lo;
    end
    if (q > 48'd2147483648) begin
      return 32'sh80000000;
    end
    return -lo;
  endfunction

  function automatic logic signed [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] v;
    unique case (idx)
      5'd0:  v = 32'sd51472;
      5'd1:  v = 32'sd30386;
      5'd2:  v = 32'sd16055;
      5'd3:  v = 32'sd8150;
      5'd4:  v = 32'sd4091;
      5'd5:  v = 32'sd2047;
      5'd6:  v = 32'sd1024;
      5'd7:  v = 32'sd512;
      5'd8:  v = 32'sd256;
      5'd9:  v = 32'sd128;
      5'd10: v = 32'sd64;
      5'd11: v = 32'sd32;
      5'd12: v = 32'sd16;
      5'd13: v = 32'sd8;
      5'd14: v = 32'sd4;
      5'd15: v = 32'sd2;
      5'd16: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/kalman_tilt_heading_filter_unit.sv
// ---------------------------------------------------------------------------
// kalman_tilt_heading_filter_unit
// Two-state Kalman filter for roll, pitch and heading in Q16.16.
// ---------------------------------------------------------------------------
// Each request runs one predict/update step on one axis (roll, pitch or
// heading) and returns one result. The block takes one request at a time and
// stalls its input until the result is handed to the output register; a new
// request may enter while that result still waits. A request runs an accept
// step, the atan2 CORDIC of 16 steps by default (the time step comes from a
// reciprocal multiply meanwhile), seven measurement and predict steps, two
// gain quotients on the shared radix-2 divider, seven update steps and one
// hand-off step. One shared 32x32 multiplier steps through the rest. When
// the innovation variance is not positive the gains are skipped. A zero
// measurement vector skips the CORDIC. A stalled result holds the hand-off
// step until the output register is free.
module kalman_tilt_heading_filter_unit #(
  parameter int CORDIC_STEPS = kthf_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  kthf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output kthf_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import kthf_pkg::*;

  state_t state, state_next;

  logic [9:0]  period;
  logic [15:0] angle_n, bias_n, meas_n;

  logic signed [31:0] angle_est [3];
  logic signed [31:0] gyro_bias [3];
  logic signed [31:0] cov_00 [3];
  logic signed [31:0] cov_01 [3];
  logic signed [31:0] cov_10 [3];
  logic signed [31:0] cov_11 [3];

  in_t                in_q;
  logic [1:0]         axis, axis_sel;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] dt, rate, meas, t11, tt, y, s_reg, k0, k1, mreg;
  logic signed [31:0] mul_a, mul_b, s_val;
  logic signed [63:0] prod;
  logic signed [47:0] head_sum;
  logic               div_neg, out_free;

  logic               div_start, div_busy;
  logic [DIV_W-1:0]   div_num, div_quo;
  logic [31:0]        div_den;
  logic [9:0]         ms1;
  logic [31:0]        dt_num;

  logic               cor_start, cor_busy;
  logic signed [16:0] cor_y, cor_x;
  logic signed [31:0] cor_angle;

  kthf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  kthf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .busy  (cor_busy),
    .angle (cor_angle)
  );

  assign axis_sel = in_data.kind ? 2'd2 : {1'b0, in_data.tilt_axis};
  assign out_free = !out_valid || !out_stall;
  assign ms1      = (period == '0) ? 10'd1 : period;
  assign dt_num   = {6'b0, ms1, 16'b0} + DT_ROUND;
  assign s_val    = sat32(48'(p00) + 48'(meas_n));
  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign head_sum = 48'(mreg) + DEG270;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_PRE;
      S_PRE:   if (!cor_busy) state_next = S_MEAS;
      S_MEAS:  state_next = S_P0;
      S_P0:    state_next = S_P1;
      S_P1:    state_next = S_P2;
      S_P2:    state_next = S_P3;
      S_P3:    state_next = S_P4;
      S_P4:    state_next = S_P5;
      S_P5:    state_next = (s_val > 0) ? S_K0 : S_U1;
      S_K0:    if (!div_busy) state_next = S_K1;
      S_K1:    if (!div_busy) state_next = S_U1;
      S_U1:    state_next = S_U2;
      S_U2:    state_next = S_U3;
      S_U3:    state_next = S_U4;
      S_U4:    state_next = S_U5;
      S_U5:    state_next = S_U6;
      S_U6:    state_next = S_U7;
      S_U7:    state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    in_stall  = (state != S_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cor_start = 1'b0;
    cor_y     = in_data.kind ? 17'(in_data.mag_z) + MAG_Z_OFS : 17'(in_data.acc_first);
    cor_x     = in_data.kind ? 17'(in_data.mag_x) - MAG_X_OFS : 17'(in_data.acc_second);
    unique case (state)
      S_IDLE: begin
        cor_start = in_valid;
      end
      S_PRE: begin
        mul_a = dt_num;
        mul_b = DT_RECIP;
      end
      S_MEAS: begin
        mul_a = cor_angle;
        mul_b = in_q.kind ? K_HEAD : K_TILT;
      end
      S_P0: begin mul_a = dt; mul_b = rate; end
      S_P1: begin mul_a = dt; mul_b = p11; end
      S_P3: begin mul_a = dt; mul_b = tt; end
      S_P4: begin mul_a = 32'(bias_n); mul_b = dt; end
      S_P5: begin
        div_start = (s_val > 0);
        div_num   = {(p00[31] ? -p00 : p00), 16'b0};
        div_den   = s_val;
      end
      S_K0: begin
        div_start = !div_busy;
        div_num   = {(p10[31] ? -p10 : p10), 16'b0};
        div_den   = s_reg;
      end
      S_U1: begin mul_a = k0; mul_b = y; end
      S_U2: begin mul_a = k1; mul_b = y; end
      S_U3: begin mul_a = k1; mul_b = p00; end
      S_U4: begin mul_a = k1; mul_b = p01; end
      S_U5: begin mul_a = k0; mul_b = p01; end
      S_U6: begin mul_a = k0; mul_b = p00; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= 10'd10;
      angle_n <= 16'd66;
      bias_n  <= 16'd197;
      meas_n  <= 16'd1966;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PERIOD:  period  <= cfg_data[9:0];
        REG_ANGLE_N: angle_n <= cfg_data;
        REG_BIAS_N:  bias_n  <= cfg_data;
        REG_MEAS_N:  meas_n  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-axis filter state; write back when the result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        angle_est[k] <= '0;
        gyro_bias[k] <= '0;
        cov_00[k]    <= '0;
        cov_01[k]    <= '0;
        cov_10[k]    <= '0;
        cov_11[k]    <= '0;
      end
    end else if (state == S_DONE && out_free) begin
      angle_est[axis] <= ang;
      gyro_bias[axis] <= bias;
      cov_00[axis]    <= p00;
      cov_01[axis]    <= p01;
      cov_10[axis]    <= p10;
      cov_11[axis]    <= p11;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    mreg <= qround(prod);
    unique case (state)
      S_IDLE: if (in_valid) begin
        in_q <= in_data;
        axis <= axis_sel;
        ang  <= angle_est[axis_sel];
        bias <= gyro_bias[axis_sel];
        p00  <= cov_00[axis_sel];
        p01  <= cov_01[axis_sel];
        p10  <= cov_10[axis_sel];
        p11  <= cov_11[axis_sel];
      end
      S_PRE:  dt <= {15'b0, prod[DT_SHIFT+16:DT_SHIFT]};
      S_MEAS: rate <= sat32(48'(in_q.gyro_rate) * GYRO_SCALE - 48'(bias));
      S_P0: begin
        if (in_q.kind) begin
          meas <= sat32((head_sum > DEG360) ? head_sum - DEG360 : head_sum);
        end else begin
          meas <= mreg;
        end
      end
      S_P1: ang <= sat32(48'(ang) + 48'(mreg));
      S_P2: begin
        t11 <= mreg;
        tt  <= sat32(48'(mreg) - 48'(p01) - 48'(p10) + 48'(angle_n));
      end
      S_P4: begin
        p00 <= sat32(48'(p00) + 48'(mreg));
        p01 <= sat32(48'(p01) - 48'(t11));
        p10 <= sat32(48'(p10) - 48'(t11));
      end
      S_P5: begin
        p11     <= sat32(48'(p11) + 48'(mreg));
        y       <= sat32(48'(meas) - 48'(ang));
        s_reg   <= s_val;
        div_neg <= p00[31];
        k0      <= '0;
        k1      <= '0;
      end
      S_K0: if (!div_busy) begin
        k0      <= gain_fix(div_quo, div_neg);
        div_neg <= p10[31];
      end
      S_K1: if (!div_busy) k1 <= gain_fix(div_quo, div_neg);
      S_U2: ang  <= sat32(48'(ang) + 48'(mreg));
      S_U3: bias <= sat32(48'(bias) + 48'(mreg));
      S_U4: p10  <= sat32(48'(p10) - 48'(mreg));
      S_U5: p11  <= sat32(48'(p11) - 48'(mreg));
      S_U6: p01  <= sat32(48'(p01) - 48'(mreg));
      S_U7: p00  <= sat32(48'(p00) - 48'(mreg));
      S_DONE: if (out_free) begin
        out_data.axis_id        <= axis;
        out_data.filtered_angle <= ang;
        out_data.measured_angle <= meas;
      end
      default: ;
    endcase
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared outside the final step");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_units_done: assert property (@(posedge clk) disable iff (rst)
    state == S_MEAS |-> !cor_busy && !div_busy)
    else $error("measurement step entered while atan2 or divider busy");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_PRE)
    else $error("accepted request did not start the sequence");

endmodule

// File: rtl/core/kthf_div.sv
// ---------------------------------------------------------------------------
// kthf_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module kthf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kthf_pkg::DIV_W-1:0]  num,
  input  logic [31:0]                 den,
  output logic                        busy,
  output logic [kthf_pkg::DIV_W-1:0]  quo
);
  import kthf_pkg::*;

  logic [32:0]          rem;
  logic [32:0]          rem_sh;
  logic [DIV_W-1:0]     q;
  logic [31:0]          d;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 fits;

  always_comb begin
    rem_sh = {rem[31:0], q[DIV_W-1]};
    fits   = rem_sh >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      d   <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, d} : rem_sh;
      q   <= {q[DIV_W-2:0], fits};
    end
  end

  assign quo = q;

endmodule

// File: rtl/core/kthf_cordic.sv
// ---------------------------------------------------------------------------
// kthf_cordic
// Vectoring CORDIC atan2 in Q16.16 radians, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
module kthf_cordic #(
  parameter int STEPS = kthf_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] y_in,
  input  logic signed [16:0] x_in,
  output logic               busy,
  output logic signed [31:0] angle
);
  import kthf_pkg::*;

  localparam int CW = 34;
  localparam int IW = $clog2(STEPS);

  logic signed [CW-1:0] x, y, xs0, ys0, xsh, ysh;
  logic signed [31:0]   z, at;
  logic [IW-1:0]        i;

  always_comb begin
    xs0 = CW'(x_in) <<< 14;
    ys0 = CW'(y_in) <<< 14;
    xsh = x >>> i;
    ysh = y >>> i;
    at  = atan_lut(ATAN_IDX_W'(i));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
    end else if (start) begin
      busy <= (x_in != '0) || (y_in != '0);
      i    <= '0;
    end else if (busy) begin
      i <= i + 1'b1;
      if (i == IW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // pre-rotate the left half plane by a quarter turn
      if (xs0 < 0) begin
        if (ys0 >= 0) begin
          x <= ys0;
          y <= -xs0;
          z <= HALF_PI_Q;
        end else begin
          x <= -ys0;
          y <= xs0;
          z <= -HALF_PI_Q;
        end
      end else begin
        x <= xs0;
        y <= ys0;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ysh;
        y <= y - xsh;
        z <= z + at;
      end else begin
        x <= x - ysh;
        y <= y + xsh;
        z <= z - at;
      end
    end
  end

  assign angle = z;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Regression bench for the tilt/heading Kalman filter unit.
// Requests go in through a valid/stall channel; a fixed-point predictor
// computes the expected angle per axis and a checker compares every result.
// ---------------------------------------------------------------------------
module tb;
  import kthf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  kalman_tilt_heading_filter_unit dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  initial forever #5 clk = ~clk;

  // predictor state
  longint period_ms = 10, ang_q = 66, bias_q = 197, meas_q = 1966;
  longint est[3], bias[3], p00[3], p01[3], p10[3], p11[3];
  out_t angle_queue[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_out = 0;
  int hold_cycles = 0;
  bit quiet_out = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return clamp32(floor_shr(a * b + 32768, 16));
  endfunction

  function automatic longint fdiv(longint p, longint s);
    if (s <= 0) return 0;
    return clamp32((p * 65536) / s);
  endfunction

  function automatic longint atan_step(int i);
    longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tab[i] : 0;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 102944;
      end else begin
        t = x; x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return clamp32(z);
  endfunction

  function automatic longint filter_axis(int a, longint gyro, longint meas);
    longint ms, dt, rate, t, y, s, k0, k1, q00, q01;
    ms = (period_ms == 0) ? 1 : period_ms;
    dt = (ms * 65536 + 500) / 1000;
    rate = clamp32(gyro * 500 - bias[a]);
    est[a] = clamp32(est[a] + fmul(dt, rate));
    t = clamp32(fmul(dt, p11[a]) - p01[a] - p10[a] + ang_q);
    p00[a] = clamp32(p00[a] + fmul(dt, t));
    t = fmul(dt, p11[a]);
    p01[a] = clamp32(p01[a] - t);
    p10[a] = clamp32(p10[a] - t);
    p11[a] = clamp32(p11[a] + fmul(bias_q, dt));
    y = clamp32(meas - est[a]);
    s = clamp32(p00[a] + meas_q);
    k0 = fdiv(p00[a], s);
    k1 = fdiv(p10[a], s);
    est[a] = clamp32(est[a] + fmul(k0, y));
    bias[a] = clamp32(bias[a] + fmul(k1, y));
    q00 = p00[a];
    q01 = p01[a];
    p00[a] = clamp32(p00[a] - fmul(k0, q00));
    p01[a] = clamp32(p01[a] - fmul(k0, q01));
    p10[a] = clamp32(p10[a] - fmul(k1, q00));
    p11[a] = clamp32(p11[a] - fmul(k1, q01));
    return est[a];
  endfunction

  function automatic out_t predict_angle(in_t r);
    out_t o;
    longint m, h;
    int a;
    if (r.kind) begin
      h = fmul(vector_angle(longint'(r.mag_z) + 127, longint'(r.mag_x) - 102), -3754951)
          + 270 * 65536;
      if (h > 360 * 65536) h -= 360 * 65536;
      m = clamp32(h);
      a = 2;
    end else begin
      m = fmul(vector_angle(longint'(r.acc_first), longint'(r.acc_second)), 3756841);
      a = r.tilt_axis;
    end
    o.axis_id = a[1:0];
    o.filtered_angle = 32'(filter_axis(a, longint'(r.gyro_rate), m));
    o.measured_angle = 32'(m);
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic tick(int n);
    repeat (n) @(posedge clk);
  endtask

  // send one request, then an optional random gap
  task automatic send(in_t r, bit gaps = 1);
    int g;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    angle_queue.push_back(predict_angle(r));
    g = 0;
    if (gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: g = 0;
        5, 6, 7: g = $urandom_range(1, 4);
        8: g = $urandom_range(5, 40);
        default: g = $urandom_range(100, 400);
      endcase
    end
    if (g > 0) begin
      in_valid <= 1'b0;
      tick(g);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    tick(200);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PERIOD: period_ms = v[9:0];
      REG_ANGLE_N: ang_q = v;
      REG_BIAS_N: bias_q = v;
      default: meas_q = v;
    endcase
  endtask

  function automatic in_t any_request();
    in_t r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(in_t)-1:0];
    return r;
  endfunction

  // mostly sensor-like samples so the filter tracks; some raw noise
  function automatic in_t plausible_request();
    in_t r;
    r = any_request();
    if ($urandom_range(0, 3) != 0) begin
      r.gyro_rate = 16'($signed($urandom_range(0, 400)) - 200);
      r.acc_first = 16'($signed($urandom_range(0, 32000)) - 16000);
      r.acc_second = 16'($signed($urandom_range(0, 32000)) - 16000);
    end
    return r;
  endfunction

  // checker
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      cycles <= cycles + 1;
      if (out_valid && !out_stall) begin
        if (angle_queue.size() == 0) begin
          $display("unexpected result at cycle %0d", cycles);
          errors++;
        end else begin
          want = angle_queue.pop_front();
          if (out_data.axis_id !== want.axis_id)
            report("axis_id", 32'(out_data.axis_id), 32'(want.axis_id));
          if (out_data.filtered_angle !== want.filtered_angle)
            report("filtered_angle", out_data.filtered_angle, want.filtered_angle);
          if (out_data.measured_angle !== want.measured_angle)
            report("measured_angle", out_data.measured_angle, want.measured_angle);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (hold_out) begin
      out_stall <= 1'b1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          hold_cycles <= $urandom_range(0, 5);
          out_stall <= 1'b1;
        end
        3: begin
          hold_cycles <= $urandom_range(20, 300);
          out_stall <= 1'b1;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  initial begin
    wait (cycles > 64'd12000000);
    $display("kalman_tilt_heading_filter_unit regression: fail");
    $finish;
  end

  task automatic test_directed();
    in_t r;
    logic signed [15:0] ext[5] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF};
    for (int i = 0; i < 5; i++) begin
      r = '0;
      r.tilt_axis = i[0];
      r.gyro_rate = ext[i];
      r.acc_first = ext[i];
      r.acc_second = ext[4 - i];
      send(r);
    end
    r = '0;
    send(r);                        // zero vector on tilt
    r.kind = 1'b1;
    r.mag_x = 16'sd102; r.mag_z = -16'sd127;
    send(r);                        // zero vector on heading
    for (int i = 0; i < 5; i++) begin
      r = '0;
      r.kind = 1'b1;
      r.tilt_axis = 1'b1;
      r.acc_first = 16'hFFFF;
      r.acc_second = 16'hFFFF;
      r.gyro_rate = ext[i];
      r.mag_x = ext[i];
      r.mag_z = ext[(i + 2) % 5];
      send(r);
    end
    // quadrant boundaries
    r = '0; r.acc_first = 16'sd100; r.acc_second = -16'sd100; send(r);
    r.acc_first = -16'sd100; send(r);
    r.acc_first = 16'sd0; send(r);
    r.acc_first = 16'sd100; r.acc_second = 16'sd0; send(r);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [15:0] periods[4] = '{16'd1, 16'd1000, 16'd0, 16'd1023};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_PERIOD, periods[p]);
      write_reg(REG_ANGLE_N, (p % 2) ? 16'hFFFF : 16'h0000);
      write_reg(REG_BIAS_N, (p % 2) ? 16'h0000 : 16'hFFFF);
      write_reg(REG_MEAS_N, (p == 2) ? 16'h0000 : ((p == 1) ? 16'hFFFF : 16'd1));
      for (int i = 0; i < 60; i++) send((i % 4 == 0) ? any_request() : plausible_request());
      drain();
    end
    write_reg(REG_PERIOD, 16'd10);
    write_reg(REG_ANGLE_N, 16'd66);
    write_reg(REG_BIAS_N, 16'd197);
    write_reg(REG_MEAS_N, 16'd1966);
  endtask

  task automatic test_backpressure();
    // hold the output so the block fills and stalls its input
    hold_out = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++) send(plausible_request(), 0);
      end
      begin
        int n = 0;
        while (n < 2000) begin
          @(posedge clk);
          n++;
        end
        hold_out = 1'b0;
      end
    join
    drain();
    // stream with no idling on either side
    quiet_out = 1'b1;
    for (int i = 0; i < 40; i++) send(plausible_request(), 0);
    drain();
    quiet_out = 1'b0;
  endtask

  task automatic test_random();
    for (int i = 0; i < 1500; i++) begin
      send((i % 5 == 0) ? any_request() : plausible_request());
      if (i % 300 == 299) begin
        drain();
        write_reg(REG_PERIOD, 16'($urandom_range(0, 1023)));
        write_reg(REG_ANGLE_N, 16'($urandom));
        write_reg(REG_BIAS_N, 16'($urandom));
        write_reg(REG_MEAS_N, 16'($urandom_range(1, 65535)));
      end
    end
    drain();
  endtask

  initial begin
    tick(8);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("kalman_tilt_heading_filter_unit regression: pass");
    end else begin
      $display("kalman_tilt_heading_filter_unit regression: fail");
    end
    $finish;
  end
endmodule
